// ===== sv/assert_macros.svh =====
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds on every clock edge outside reset
`define CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property holds in the cycle after the condition
`define CHK_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ===== sv/tlprs_pkg.sv =====
// Package: types and constants of the two-level scheduler.
package tlprs_pkg;
  localparam int SLOTS = 16;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic [1:0] LVL_IDLE = 2'd0;
  localparam logic [1:0] LVL_TOP = 2'd1;
  localparam logic [1:0] LVL_RR = 2'd2;
  localparam logic CFG_TOP_Q = 1'b0;
  localparam logic CFG_RR_Q = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [3:0] slot;
    logic [15:0] arrival;
    logic [7:0] burst;
    logic [7:0] prio;
  } in_word_t;

  typedef struct packed {
    logic [15:0] time_now;
    logic [1:0]  run_level;
    logic [3:0]  run_slot;
    logic        first_run;
    logic [15:0] response;
    logic        done_res;
    logic [15:0] finish_time;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_finished;
  } out_word_t;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_PUSH, ST_EXEC, ST_OUT} state_t;

  function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
    sat_sub = (a > b) ? a - b : 16'd0;
  endfunction
endpackage

// ===== sv/two_level_priority_rr_scheduler.sv =====
// Top level: input queue, scheduler sequencer and result register.
// Sequencing: a load word goes from ST_IDLE straight to ST_OUT; a tick word
// passes ST_SCAN over every slot, then ST_DECIDE, ST_PUSH and ST_EXEC.
// A new word is taken from the queue only after the result is popped in ST_OUT.
// The input queue holds two words so pushes continue while a tick is scanned.
// Synchronous reset clears slots, queue and clock and sets both quanta to 4.
module two_level_priority_rr_scheduler (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tlprs_pkg::in_word_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output tlprs_pkg::out_word_t dout,
  input  logic cfg_we,
  input  logic cfg_idx,
  input  logic [3:0] cfg_data
);
  import tlprs_pkg::*;
`include "assert_macros.svh"
  logic q_empty, q_pop, res_valid;
  in_word_t q_word;
  out_word_t res;
  tlprs_fifo u_fifo (.clk, .rst, .push, .din, .full, .pop(q_pop), .empty(q_empty),
    .dout(q_word));
  tlprs_core u_core (.clk, .rst, .cfg_we, .cfg_idx, .cfg_data, .in_empty(q_empty),
    .in_word(q_word), .in_pop(q_pop), .res_valid, .res, .res_take(pop));
  assign empty = !res_valid;
  assign dout = res;

  `CHK(a_lvl, empty || dout.run_level != 2'd3, "bad run level")
  `CHK_NEXT(a_hold, !empty && !pop, !empty, "result dropped")
  `CHK(a_idle, empty || dout.run_level != LVL_IDLE || !dout.done_res, "done while idle")
endmodule

// ===== sv/tlprs_fifo.sv =====
// Small queue of input words between the front and the sequencer.
module tlprs_fifo (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tlprs_pkg::in_word_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output tlprs_pkg::in_word_t dout
);
  import tlprs_pkg::*;
  in_word_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign dout = mem[rp];
  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= din;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push && !full) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      cnt <= cnt + 2'(push && !full) - 2'(pop && !empty);
    end
  end
endmodule

// ===== sv/tlprs_core.sv =====
// Scheduler sequencer: slot scan, queue updates and result word.
module tlprs_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_idx,
  input  logic [3:0] cfg_data,
  input  logic in_empty,
  input  tlprs_pkg::in_word_t in_word,
  output logic in_pop,
  output logic res_valid,
  output tlprs_pkg::out_word_t res,
  input  logic res_take
);
  import tlprs_pkg::*;
  state_t state, state_next;
  logic [3:0] top_q, rr_q;
  logic [SLOTS-1:0] valid, demoted, started;
  logic [15:0] arr [SLOTS];
  logic [7:0] tot [SLOTS], pri [SLOTS], rem [SLOTS];
  logic [3:0] slice [SLOTS];
  logic [SW-1:0] rrf [SLOTS];
  logic [SW-1:0] head;
  logic [CW-1:0] rcnt;
  logic [15:0] clk_now;
  logic [CW-1:0] last_top;
  logic [CW-1:0] idx;
  logic [CW-1:0] best;
  logic [7:0] bestp;
  in_word_t cur;
  out_word_t o;
  logic [SW-1:0] pend_push;
  logic pend_v;
  logic [SW-1:0] si, f, b, run_s;
  logic elig;
  logic [15:0] fin, ta;
  logic allf;

  assign si = idx[SW-1:0];
  assign elig = valid[si] && arr[si] <= clk_now && rem[si] != 8'd0 && !demoted[si];
  assign f = rrf[head];
  assign b = best[SW-1:0];
  assign run_s = (best == CW'(SLOTS)) ? f : b;
  assign fin = (clk_now < 16'hFFFF) ? clk_now + 16'd1 : 16'hFFFF;
  assign ta = sat_sub(fin, arr[run_s]);
  assign in_pop = (state == ST_IDLE) && !in_empty;
  assign res_valid = state == ST_OUT;

  always_comb begin
    allf = 1'b1;
    for (int i = 0; i < SLOTS; i++) if (valid[i] && rem[i] != 8'd0) allf = 1'b0;
  end

  // slot state is settled while in ST_OUT
  always_comb begin
    res = o;
    res.all_finished = allf;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (!in_empty) state_next = (in_word.cmd == CMD_TICK) ? ST_SCAN : ST_OUT;
      ST_SCAN: if (idx == CW'(SLOTS - 1)) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_PUSH;
      ST_PUSH: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_OUT;
      ST_OUT: if (res_take) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_q <= 4'd4; rr_q <= 4'd4;
      valid <= '0; demoted <= '0; started <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        rem[i] <= 8'd0; slice[i] <= 4'd0;
      end
      head <= '0; rcnt <= '0; clk_now <= 16'd0; last_top <= CW'(SLOTS);
      pend_v <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_TOP_Q) top_q <= cfg_data;
        else rr_q <= cfg_data;
      end
      case (state)
        ST_IDLE: if (!in_empty) begin
          cur <= in_word;
          o <= out_word_t'{time_now: clk_now, default: '0};
          idx <= '0;
          best <= CW'(SLOTS);
          bestp <= 8'd0;
          pend_v <= 1'b0;
          if (in_word.cmd == CMD_LOAD && !valid[in_word.slot[SW-1:0]]) begin
            valid[in_word.slot[SW-1:0]] <= 1'b1;
            arr[in_word.slot[SW-1:0]] <= in_word.arrival;
            tot[in_word.slot[SW-1:0]] <= in_word.burst;
            pri[in_word.slot[SW-1:0]] <= in_word.prio;
            rem[in_word.slot[SW-1:0]] <= in_word.burst;
            demoted[in_word.slot[SW-1:0]] <= 1'b0;
            started[in_word.slot[SW-1:0]] <= 1'b0;
            slice[in_word.slot[SW-1:0]] <= 4'd0;
          end
        end
        ST_SCAN: begin
          if (elig && (best == CW'(SLOTS) || pri[si] < bestp)) begin
            best <= idx; bestp <= pri[si];
          end
          idx <= idx + CW'(1);
        end
        ST_DECIDE: begin
          // top task pre-empts a round-robin slice in progress: requeue front
          if (best != CW'(SLOTS) && rcnt != '0 && last_top == CW'(SLOTS)
              && slice[f] != 4'd0) begin
            if (rcnt < CW'(SLOTS)) rrf[SW'(head + rcnt[SW-1:0])] <= f;
            head <= head + SW'(1);
          end
          if (last_top < CW'(SLOTS) && best != last_top && !demoted[last_top[SW-1:0]]) begin
            pend_v <= 1'b1; pend_push <= last_top[SW-1:0];
            demoted[last_top[SW-1:0]] <= 1'b1;
          end
        end
        ST_PUSH: begin
          if (pend_v && rcnt < CW'(SLOTS)) begin
            rrf[SW'(head + rcnt[SW-1:0])] <= pend_push;
            rcnt <= rcnt + CW'(1);
          end
        end
        ST_EXEC: begin
          if (cur.cmd == CMD_TICK) begin
            if (clk_now < 16'hFFFF) clk_now <= clk_now + 16'd1;
            if (best == CW'(SLOTS) && rcnt != '0) begin
              last_top <= CW'(SLOTS);
              if (rem[f] == 8'd0) begin
                head <= head + SW'(1); rcnt <= rcnt - CW'(1);
              end else begin
                o.run_level <= LVL_RR;
                o.run_slot <= 4'(f);
                if (!started[f]) begin
                  started[f] <= 1'b1; o.first_run <= 1'b1;
                  o.response <= sat_sub(clk_now, arr[f]);
                end
                rem[f] <= rem[f] - 8'd1;
                if (rem[f] == 8'd1) begin
                  slice[f] <= (slice[f] < 4'd15) ? slice[f] + 4'd1 : slice[f];
                  o.done_res <= 1'b1; o.finish_time <= fin; o.turnaround <= ta;
                  o.waiting <= sat_sub(ta, {8'd0, tot[f]});
                  head <= head + SW'(1); rcnt <= rcnt - CW'(1);
                end else if (((slice[f] < 4'd15) ? slice[f] + 4'd1 : slice[f]) >= rr_q) begin
                  slice[f] <= 4'd0;
                  rrf[SW'(head + rcnt[SW-1:0])] <= f;
                  head <= head + SW'(1);
                end else begin
                  slice[f] <= slice[f] + 4'd1;
                end
              end
            end else begin
              if (best != CW'(SLOTS)) begin
                o.run_level <= LVL_TOP;
                o.run_slot <= 4'(b);
                if (!started[b]) begin
                  started[b] <= 1'b1; o.first_run <= 1'b1;
                  o.response <= sat_sub(clk_now, arr[b]);
                end
                rem[b] <= rem[b] - 8'd1;
                if (rem[b] == 8'd1) begin
                  o.done_res <= 1'b1; o.finish_time <= fin; o.turnaround <= ta;
                  o.waiting <= sat_sub(ta, {8'd0, tot[b]});
                  demoted[b] <= 1'b1;
                end else if (tot[b] - (rem[b] - 8'd1) == {4'd0, top_q}) begin
                  demoted[b] <= 1'b1;
                  if (rcnt < CW'(SLOTS)) begin
                    rrf[SW'(head + rcnt[SW-1:0])] <= b;
                    rcnt <= rcnt + CW'(1);
                  end
                end
              end
              last_top <= best;
            end
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end
endmodule
